// ===== design/nsos_pkg.sv =====
// Shared types and constants for the nearest symbol occurrence search core.
// Used by the word matcher, the top level and the testbench; no dependencies.
`default_nettype none

package nsos_pkg;

  localparam int POS_W  = 16;              // position and bound width
  localparam int LEN_W  = 17;              // sequence length and result width
  localparam int SYM_W  = 2;               // symbol code width
  localparam int ACT_W  = 2;               // action code width
  localparam int LANES  = 16;              // symbols per memory word
  localparam int LANE_W = 4;               // lane index width
  localparam int WORD_W = LANES * SYM_W;   // memory word width

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PREV  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NEXT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WR_WB,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Lane qualification for one memory word under test
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LANE_W-1:0] lo_lane;
    logic [LANE_W-1:0] hi_lane;
    logic              at_lo_word;
    logic              at_hi_word;
    logic              up;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== design/nsos_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
`default_nettype none

module nsos_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/nsos_word_match.sv =====
// Checks the lanes of one memory word against the searched symbol and range,
// and picks the nearest hit in the scan direction. Depends on nsos_pkg.
`default_nettype none

module nsos_word_match (
  input  wire logic [nsos_pkg::WORD_W-1:0] word,
  input  wire nsos_pkg::lane_ctl_t         ctl,
  output logic                             hit,
  output logic [nsos_pkg::LANE_W-1:0]      hit_lane
);

  localparam int LANES  = nsos_pkg::LANES;
  localparam int LANE_W = nsos_pkg::LANE_W;
  localparam int SYM_W  = nsos_pkg::SYM_W;

  logic [LANES-1:0] match;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      match[l] = (word[l*SYM_W +: SYM_W] == ctl.sym)
              && (!ctl.at_lo_word || (LANE_W'(l) >= ctl.lo_lane))
              && (!ctl.at_hi_word || (LANE_W'(l) <= ctl.hi_lane));
    end
  end

  // Upward scan wants the lowest lane, downward the highest
  always_comb begin
    hit      = |match;
    hit_lane = '0;
    if (ctl.up) begin
      for (int l = LANES - 1; l >= 0; l--) begin
        if (match[l]) begin
          hit_lane = LANE_W'(l);
        end
      end
    end else begin
      for (int l = 0; l < LANES; l++) begin
        if (match[l]) begin
          hit_lane = LANE_W'(l);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/nearest_symbol_occurrence_search_core.sv =====
// Write: decode and read the addressed word, then write back the merged word.
// Query: accept and decode, then read the 16-symbol memory words in scan order through
// the registered read port, then load the result into the output register.
// A query over n positions scans up to ceil(n/16)+1 words through the single read port.
// Reset (synchronous, active low) clears control and sets seq_length to 65536; the
// symbol memory is not cleared and holds nothing defined until written.
`default_nettype none

module nearest_symbol_occurrence_search_core #(
  parameter int SEQ_DEPTH   = 65536,
  parameter int NUM_SYMBOLS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_position,
  input  wire logic [1:0]  in_symbol,
  input  wire logic [15:0] in_bound,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      out_found_position,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_seq_length
);

  localparam int LANES   = nsos_pkg::LANES;
  localparam int LANE_W  = nsos_pkg::LANE_W;
  localparam int SYM_W   = nsos_pkg::SYM_W;
  localparam int ACT_W   = nsos_pkg::ACT_W;
  localparam int POS_W   = nsos_pkg::POS_W;
  localparam int LW      = nsos_pkg::LEN_W;
  localparam int WORD_W  = nsos_pkg::WORD_W;
  localparam int WD_RAW  = (SEQ_DEPTH + LANES - 1) / LANES;
  localparam int WDEPTH  = (WD_RAW < 2) ? 2 : WD_RAW;
  localparam int WAW     = $clog2(WDEPTH);
  localparam int LEN_MAX = (1 << LW) - 1;
  localparam logic [LW-1:0] LEN_CAP = LW'((SEQ_DEPTH >= LEN_MAX) ? LEN_MAX : SEQ_DEPTH);
  localparam logic [LW-1:0] LEN_RST = LW'(65536);

  nsos_pkg::state_t state_r, state_nxt;

  logic [ACT_W-1:0] act_r;
  logic [POS_W-1:0] pos_r;
  logic [SYM_W-1:0] sym_r;
  logic [POS_W-1:0] bound_r;
  logic [LW-1:0]    seq_len_r;

  logic [WAW-1:0]    iss_w_r;
  logic              iss_done_r;
  logic              pend_r;
  logic [WAW-1:0]    pw_r;
  logic [WAW-1:0]    fw_r;
  logic [WAW-1:0]    lo_w_r;
  logic [WAW-1:0]    hi_w_r;
  logic [LANE_W-1:0] lo_l_r;
  logic [LANE_W-1:0] hi_l_r;
  logic              up_r;
  logic [LW-1:0]     none_r;
  logic [LW-1:0]     res_r;
  logic              out_valid_r;
  logic [LW-1:0]     out_pos_r;

  // memory port
  logic              mem_rd_en;
  logic [WAW-1:0]    mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [WAW-1:0]    mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;

  // query decode
  logic [LW-1:0]  eff_len, len_m1, pos_x, bnd_x;
  logic [LW-1:0]  prev_p, next_last, next_none;
  logic [LW-1:0]  q_lo, q_hi, q_none;
  logic           sym_ok, empty, trivial, wr_ok, is_up;
  logic [WAW-1:0] q_lo_w, q_hi_w, pos_w;

  // word matcher
  nsos_pkg::lane_ctl_t     ctl;
  logic                    hit;
  logic [LANE_W-1:0]       hit_lane;
  logic                    scan_last;

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_found_position = out_pos_r;

  always_comb begin
    eff_len   = (seq_len_r < LEN_CAP) ? seq_len_r : LEN_CAP;
    len_m1    = eff_len - LW'(1);
    pos_x     = LW'(pos_r);
    bnd_x     = LW'(bound_r);
    sym_ok    = ({1'b0, sym_r} < (SYM_W + 1)'(NUM_SYMBOLS));
    empty     = (eff_len == '0) || !sym_ok;
    prev_p    = (pos_x < eff_len) ? pos_x : len_m1;
    next_last = (bnd_x < len_m1) ? bnd_x : len_m1;
    next_none = (bnd_x < seq_len_r) ? bnd_x : seq_len_r;
    is_up     = (act_r == nsos_pkg::ACT_NEXT);
    if (is_up) begin
      q_lo    = pos_x;
      q_hi    = next_last;
      q_none  = next_none;
      trivial = empty || (pos_x > next_last);
    end else begin
      q_lo    = bnd_x;
      q_hi    = prev_p;
      q_none  = bnd_x;
      trivial = empty || (prev_p < bnd_x);
    end
    q_lo_w = WAW'(q_lo >> LANE_W);
    q_hi_w = WAW'(q_hi >> LANE_W);
    pos_w  = WAW'(pos_r >> LANE_W);
    wr_ok  = (32'(pos_r) < 32'(SEQ_DEPTH)) && sym_ok;
  end

  always_comb begin
    ctl.sym        = sym_r;
    ctl.lo_lane    = lo_l_r;
    ctl.hi_lane    = hi_l_r;
    ctl.at_lo_word = (pw_r == lo_w_r);
    ctl.at_hi_word = (pw_r == hi_w_r);
    ctl.up         = up_r;
    scan_last      = (pw_r == fw_r);
  end

  nsos_word_match u_match (
    .word     (mem_rd_data),
    .ctl      (ctl),
    .hit      (hit),
    .hit_lane (hit_lane)
  );

  nsos_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (WDEPTH),
    .ADDR_W (WAW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nsos_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nsos_pkg::ST_DECODE;
        end
      end
      nsos_pkg::ST_DECODE: begin
        case (act_r)
          nsos_pkg::ACT_WRITE: state_nxt = wr_ok ? nsos_pkg::ST_WR_WB : nsos_pkg::ST_IDLE;
          nsos_pkg::ACT_PREV,
          nsos_pkg::ACT_NEXT:  state_nxt = trivial ? nsos_pkg::ST_RESP : nsos_pkg::ST_SCAN;
          default:             state_nxt = nsos_pkg::ST_IDLE;
        endcase
      end
      nsos_pkg::ST_WR_WB: begin
        state_nxt = nsos_pkg::ST_IDLE;
      end
      nsos_pkg::ST_SCAN: begin
        if (pend_r && (hit || scan_last)) begin
          state_nxt = nsos_pkg::ST_RESP;
        end
      end
      nsos_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = nsos_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nsos_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory controls; the FSM keeps writes and scans apart, so no
  // access to one word ever overlaps another
  always_comb begin
    in_stall    = (state_r != nsos_pkg::ST_IDLE);
    mem_rd_en   = 1'b0;
    mem_rd_addr = pos_w;
    mem_wr_en   = 1'b0;
    mem_wr_addr = pos_w;
    for (int l = 0; l < LANES; l++) begin
      mem_wr_data[l*SYM_W +: SYM_W] = (LANE_W'(l) == pos_r[LANE_W-1:0]) ? sym_r
                                      : mem_rd_data[l*SYM_W +: SYM_W];
    end
    case (state_r)
      nsos_pkg::ST_DECODE: begin
        mem_rd_en = (act_r == nsos_pkg::ACT_WRITE) && wr_ok;
      end
      nsos_pkg::ST_WR_WB: begin
        mem_wr_en = 1'b1;
      end
      nsos_pkg::ST_SCAN: begin
        mem_rd_en   = !iss_done_r;
        mem_rd_addr = iss_w_r;
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsos_pkg::ST_IDLE;
      seq_len_r   <= LEN_RST;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      iss_done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        seq_len_r <= cfg_seq_length;
      end
      if (state_r == nsos_pkg::ST_RESP && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        nsos_pkg::ST_DECODE: begin
          pend_r     <= 1'b0;
          iss_done_r <= 1'b0;
        end
        nsos_pkg::ST_SCAN: begin
          pend_r <= !iss_done_r;
          if (!iss_done_r && (iss_w_r == fw_r)) begin
            iss_done_r <= 1'b1;
          end
        end
        default: begin
          pend_r <= 1'b0;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state_r == nsos_pkg::ST_IDLE && in_valid) begin
      act_r   <= in_action;
      pos_r   <= in_position;
      sym_r   <= in_symbol;
      bound_r <= in_bound;
    end
    if (state_r == nsos_pkg::ST_RESP && (!out_valid_r || !out_stall)) begin
      out_pos_r <= res_r;
    end
    case (state_r)
      nsos_pkg::ST_DECODE: begin
        up_r    <= is_up;
        lo_w_r  <= q_lo_w;
        hi_w_r  <= q_hi_w;
        lo_l_r  <= q_lo[LANE_W-1:0];
        hi_l_r  <= q_hi[LANE_W-1:0];
        fw_r    <= is_up ? q_hi_w : q_lo_w;
        iss_w_r <= is_up ? q_lo_w : q_hi_w;
        none_r  <= q_none;
        res_r   <= q_none;
      end
      nsos_pkg::ST_SCAN: begin
        pw_r <= iss_w_r;
        if (!iss_done_r && (iss_w_r != fw_r)) begin
          iss_w_r <= up_r ? (iss_w_r + WAW'(1)) : (iss_w_r - WAW'(1));
        end
        if (pend_r) begin
          if (hit) begin
            res_r <= LW'({pw_r, hit_lane});
          end else if (scan_last) begin
            res_r <= none_r;
          end
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/nsos_found_position_check.sv =====
`timescale 1ns / 1ps
// Result checker for the nearest symbol occurrence search core: mirrors the symbol
// store and length register, predicts each found position and compares it.
// Depends on nsos_pkg for field widths and action codes.

module nsos_found_position_check
  import nsos_pkg::*;
#(
  parameter int SEQ_DEPTH   = 65536,
  parameter int NUM_SYMBOLS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [POS_W-1:0]  in_position,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [POS_W-1:0]  in_bound,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [LEN_W-1:0]  out_found_position,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_seq_length,
  output int                mismatches,
  output int                pending,
  output int                results_checked
);

  localparam int unsigned LENGTH_AT_RESET = 65536;

  logic [SYM_W-1:0] symbol_mem [SEQ_DEPTH];
  logic [LEN_W-1:0] length_q;
  logic [LEN_W-1:0] expected_positions [$];
  logic [LEN_W-1:0] want;

  function automatic int unsigned live_length();
    return (32'(length_q) < SEQ_DEPTH) ? 32'(length_q) : SEQ_DEPTH;
  endfunction

  // Walk down from the clipped start toward the lower bound.
  function automatic logic [LEN_W-1:0] last_at_or_before(logic [POS_W-1:0] pos,
                                                         logic [SYM_W-1:0] sym,
                                                         logic [POS_W-1:0] bnd);
    int unsigned span;
    int unsigned p;
    int unsigned lo;
    span = live_length();
    lo = 32'(bnd);
    if (span == 0 || 32'(sym) >= NUM_SYMBOLS) return LEN_W'(bnd);
    p = (32'(pos) < span) ? 32'(pos) : span - 1;
    if (p < lo) return LEN_W'(bnd);
    while (symbol_mem[POS_W'(p)] != sym) begin
      if (p == lo) return LEN_W'(bnd);
      p--;
    end
    return LEN_W'(p);
  endfunction

  // Walk up from the start toward the upper bound, clipped to the sequence end.
  function automatic logic [LEN_W-1:0] first_at_or_after(logic [POS_W-1:0] pos,
                                                         logic [SYM_W-1:0] sym,
                                                         logic [POS_W-1:0] bnd);
    int unsigned span;
    int unsigned none;
    int unsigned last;
    int unsigned p;
    span = live_length();
    none = (32'(bnd) < 32'(length_q)) ? 32'(bnd) : 32'(length_q);
    if (span == 0 || 32'(sym) >= NUM_SYMBOLS) return LEN_W'(none);
    last = (32'(bnd) < span - 1) ? 32'(bnd) : span - 1;
    for (p = 32'(pos); p <= last; p++) begin
      if (symbol_mem[POS_W'(p)] == sym) return LEN_W'(p);
    end
    return LEN_W'(none);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      length_q = LEN_W'(LENGTH_AT_RESET);
      expected_positions.delete();
    end else begin
      // Retire results before taking new words so a same-edge accept never matches.
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual found_position %0d",
                   $time, out_found_position);
        end else begin
          want = expected_positions.pop_front();
          results_checked++;
          if (out_found_position !== want) begin
            mismatches++;
            $display("%0t: found_position mismatch, expected %0d, actual %0d",
                     $time, want, out_found_position);
          end
        end
      end
      if (cfg_valid && cfg_ready) length_q = cfg_seq_length;
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_WRITE: begin
            if (32'(in_symbol) < NUM_SYMBOLS && 32'(in_position) < SEQ_DEPTH)
              symbol_mem[in_position] = in_symbol;
          end
          ACT_PREV:
            expected_positions.push_back(last_at_or_before(in_position, in_symbol, in_bound));
          ACT_NEXT:
            expected_positions.push_back(first_at_or_after(in_position, in_symbol, in_bound));
          default: ;
        endcase
      end
    end
    pending = expected_positions.size();
  end

endmodule

// ===== tb/sv/nearest_symbol_occurrence_search_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for nearest_symbol_occurrence_search_core: drives writes, queries and
// length settings with random idling and stalls; nsos_found_position_check does the checking.
// Depends on nsos_pkg, the core and the checker module.

module nearest_symbol_occurrence_search_core_tb;
  import nsos_pkg::*;

  localparam int SEQ_DEPTH      = 65536;
  localparam int NUM_SYMBOLS    = 3;
  localparam int QUIET_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 9;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam logic [SYM_W-1:0] SYM_BAD  = SYM_W'(NUM_SYMBOLS);

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ACT_W-1:0] in_action = ACT_WRITE;
  logic [POS_W-1:0] in_position = '0;
  logic [SYM_W-1:0] in_symbol = '0;
  logic [POS_W-1:0] in_bound = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [LEN_W-1:0] out_found_position;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_seq_length = '0;

  int mismatches;
  int pending;
  int results_checked;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_taken = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // Current length setting and the window of positions known to be written.
  int unsigned len_now = 65536;
  int unsigned win_lo = 0;
  int unsigned win_hi = 0;

  int unsigned writes_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned ignored_sent = 0;
  int unsigned lengths_set = 0;

  int unsigned length_plan [PHASES] = '{1, 40, 65536, 200, 0, 131071, 17, 65536, 96};

  nearest_symbol_occurrence_search_core #(
    .SEQ_DEPTH   (SEQ_DEPTH),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_symbol          (in_symbol),
    .in_bound           (in_bound),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found_position (out_found_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_seq_length     (cfg_seq_length)
  );

  nsos_found_position_check #(
    .SEQ_DEPTH   (SEQ_DEPTH),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) position_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_symbol          (in_symbol),
    .in_bound           (in_bound),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found_position (out_found_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_seq_length     (cfg_seq_length),
    .mismatches         (mismatches),
    .pending            (pending),
    .results_checked    (results_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  always @(negedge clk) begin
    if (holds_taken != holds_asked) begin
      holds_taken = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("nearest_symbol_occurrence_search_core_tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one word after a random gap; return at the falling edge after it is taken.
  task automatic send(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                      logic [SYM_W-1:0] sym, logic [POS_W-1:0] bnd);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_symbol   <= sym;
    in_bound    <= bnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    case (act)
      ACT_WRITE: writes_sent++;
      ACT_PREV, ACT_NEXT: queries_sent++;
      default: ignored_sent++;
    endcase
  endtask

  // Hold off the sender until every query has answered.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_length(int unsigned value);
    int unsigned live;
    drain();
    // writes leave no result behind, so give the last one time to land
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_seq_length <= LEN_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    lengths_set++;
    len_now = value;
    live = (value > SEQ_DEPTH) ? SEQ_DEPTH : value;
    win_hi = (live == 0) ? 0 : live - 1;
    win_lo = (live > 256) ? live - 80 : 0;
  endtask

  task automatic fill_window();
    int unsigned p;
    if (len_now != 0) begin
      for (p = win_lo; p <= win_hi; p++)
        send(ACT_WRITE, POS_W'(p), SYM_W'($urandom_range(NUM_SYMBOLS - 1)), POS_W'($urandom));
    end
  endtask

  // A query is safe when every position it can visit lies inside the written window.
  function automatic bit query_safe(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                    logic [SYM_W-1:0] sym, logic [POS_W-1:0] bnd);
    if (sym >= NUM_SYMBOLS || len_now == 0) return 1'b1;
    if (act == ACT_PREV) return (pos < bnd) || (bnd >= win_lo);
    if (act == ACT_NEXT) return (pos > bnd) || (pos >= win_lo);
    return 1'b1;
  endfunction

  task automatic send_random_word(output bit counted);
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] bnd;
    logic [SYM_W-1:0] sym;
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = win_hi - win_lo + 1;
    act = $urandom_range(1) ? ACT_PREV : ACT_NEXT;
    sym = SYM_W'($urandom_range(NUM_SYMBOLS - 1));
    pos = POS_W'($urandom);
    bnd = POS_W'($urandom);
    if (roll < 30) begin
      act = ACT_WRITE;
      if (roll < 22) pos = POS_W'(win_lo + $urandom_range(span - 1));
      if (roll < 3) sym = SYM_BAD;
    end else if (roll < 85 && len_now != 0) begin
      pos = POS_W'(win_lo + $urandom_range(span - 1));
      if (act == ACT_PREV)
        bnd = POS_W'(win_lo + $urandom_range(pos - win_lo));
      else if (roll < 78)
        bnd = POS_W'(pos + $urandom_range(win_hi - pos));
      else
        bnd = POS_W'(pos + $urandom_range(65535 - pos));
    end else if (roll < 95) begin
      sym = SYM_W'($urandom_range(3));
      if ($urandom_range(1)) begin
        pos = POS_W'($urandom_range(win_hi + 1));
        bnd = POS_W'($urandom_range(win_hi + 1));
      end
      if (!query_safe(act, pos, sym, bnd)) begin
        if (act == ACT_PREV) bnd = POS_W'(win_lo + $urandom_range(span - 1));
        else pos = POS_W'(win_lo + $urandom_range(span - 1));
      end
    end else begin
      act = ACT_NONE;
      sym = SYM_W'($urandom_range(3));
    end
    send(act, pos, sym, bnd);
    counted = (act != ACT_NONE);
  endtask

  task automatic directed_words();
    int unsigned p;
    set_length(8);
    for (p = 0; p < 8; p++) send(ACT_WRITE, POS_W'(p), SYM_W'(p % 3), '0);
    send(ACT_PREV, 16'd5, 2'd0, 16'd0);
    send(ACT_NEXT, 16'd1, 2'd0, 16'd7);
    // start beyond the sequence end
    send(ACT_PREV, 16'hFFFF, 2'd1, 16'd0);
    send(ACT_NEXT, 16'hFFFF, 2'd2, 16'hFFFF);
    // start past bound
    send(ACT_PREV, 16'd2, 2'd1, 16'd5);
    send(ACT_NEXT, 16'd7, 2'd0, 16'd2);
    // unsupported symbol: query misses, write is dropped
    send(ACT_PREV, 16'd7, SYM_BAD, 16'd1);
    send(ACT_NEXT, 16'd0, SYM_BAD, 16'hFFFF);
    send(ACT_WRITE, 16'd3, SYM_BAD, 16'd0);
    send(ACT_NEXT, 16'd1, 2'd0, 16'd7);
    send(ACT_NONE, 16'd0, 2'd2, 16'd0);
    send(ACT_PREV, 16'd0, 2'd0, 16'd0);
    send(ACT_PREV, 16'd7, 2'd2, 16'd6);
    send(ACT_NEXT, 16'd4, 2'd1, 16'd6);
    send(ACT_WRITE, 16'hFFFF, 2'd2, 16'hFFFF);
    // empty sequence
    set_length(0);
    send(ACT_PREV, 16'hFFFF, 2'd2, 16'hFFFF);
    send(ACT_NEXT, 16'd0, 2'd0, 16'hFFFF);
  endtask

  initial begin
    int ph;
    int unsigned n;
    int unsigned target;
    bit counted;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    src_idle_pct = 29;
    sink_stall_pct = 50;
    directed_words();
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 50;
        sink_stall_pct = 29;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      set_length(length_plan[ph]);
      fill_window();
      target = (len_now == 0) ? 40 : 130;
      n = 0;
      while (n < target) begin
        send_random_word(counted);
        if (counted) begin
          n++;
          // back up the block with a long receiver hold-off while words keep coming
          if ((ph == 1 || ph == 6) && n == 40) holds_asked++;
          if ((ph == 2 || ph == 7) && n == 60) drain();
        end
      end
    end
    drain();
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    $display("covered %0d writes, %0d queries (%0d results checked), %0d ignored words",
             writes_sent, queries_sent, results_checked, ignored_sent);
    $display("across %0d length settings from empty to beyond the store depth", lengths_set);
    if (mismatches == 0) begin
      $display("nearest_symbol_occurrence_search_core_tb: done, clean");
    end else begin
      $display("nearest_symbol_occurrence_search_core_tb: done, errors");
    end
    $finish;
  end

endmodule
